/* rtl/core/page_framebuffer_draw_engine_defines.svh */
// ----------------------------------------------------------------------------
// page framebuffer draw engine assertion macros
// shared property wrappers clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH

// same-cycle implication
`define PFDE_CHECK(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define PFDE_CHECK_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* rtl/core/pfde_pkg.sv */
// ----------------------------------------------------------------------------
// pfde_pkg
// command codes, shape descriptor and 5x7 font for the page draw engine
// ----------------------------------------------------------------------------
`default_nettype none

package pfde_pkg;

    localparam int COORD_W = 11;
    typedef logic signed [COORD_W-1:0] coord_t;

    localparam logic [2:0] FN_CLEAR   = 3'd0;
    localparam logic [2:0] FN_PIXEL   = 3'd1;
    localparam logic [2:0] FN_FILL    = 3'd2;
    localparam logic [2:0] FN_OUTLINE = 3'd3;
    localparam logic [2:0] FN_CHAR    = 3'd4;
    localparam logic [2:0] FN_READ    = 3'd5;

    localparam logic [1:0] SH_BOX   = 2'd0;
    localparam logic [1:0] SH_FRAME = 2'd1;
    localparam logic [1:0] SH_GLYPH = 2'd2;

    typedef logic [5:0] glyph_t;

    localparam glyph_t GL_BLANK   = 6'd0;
    localparam glyph_t GL_UNKNOWN = 6'd1;
    localparam glyph_t GL_COLON   = 6'd2;
    localparam glyph_t GL_DOT     = 6'd3;
    localparam glyph_t GL_DASH    = 6'd4;
    localparam glyph_t GL_SLASH   = 6'd5;
    localparam glyph_t GL_PERCENT = 6'd6;
    localparam glyph_t GL_GT      = 6'd7;
    localparam glyph_t GL_DIGIT0  = 6'd8;
    localparam glyph_t GL_LETTERA = 6'd18;
    localparam glyph_t GL_COUNT   = 6'd44;
    localparam int     GL_ROWS    = 44;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_Z    = 8'h5A;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_Z    = 8'h7A;
    localparam logic [7:0] CH_FOLD    = 8'h20;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_GT      = 8'h3E;

    typedef struct packed {
        logic [1:0] mode;
        coord_t     xa;
        coord_t     xb;
        coord_t     ya;
        coord_t     yb;
        logic       pen;
        logic       invert;
        glyph_t     glyph;
    } shape_t;

    // five columns per glyph, leftmost column in the top byte
    localparam logic [39:0] FONT_ROM [GL_ROWS] = '{
        40'h0000000000, 40'h3E415D413E, 40'h0036360000, 40'h0060600000,
        40'h0808080808, 40'h2010080402, 40'h6264081323, 40'h0041221408,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h7E1111117E, 40'h7F49494936,
        40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
        40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100, 40'h2040413F01,
        40'h7F08142241, 40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F,
        40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
        40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
        40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543
    };

    function automatic glyph_t pick_glyph(input logic [7:0] code);
        logic [7:0] folded;
        glyph_t     g;
        folded = code;
        if (code >= CH_LO_A && code <= CH_LO_Z)
        begin
            folded = code - CH_FOLD;
        end
        if (code == CH_SPACE)
        begin
            g = GL_BLANK;
        end
        else if (code >= CH_ZERO && code <= CH_NINE)
        begin
            g = GL_DIGIT0 + 6'(code - CH_ZERO);
        end
        else if (folded >= CH_UP_A && folded <= CH_UP_Z)
        begin
            g = GL_LETTERA + 6'(folded - CH_UP_A);
        end
        else
        begin
            unique case (folded)
                CH_COLON:           g = GL_COLON;
                CH_DOT:             g = GL_DOT;
                CH_DASH, CH_UNDER:  g = GL_DASH;
                CH_SLASH:           g = GL_SLASH;
                CH_PERCENT:         g = GL_PERCENT;
                CH_GT:              g = GL_GT;
                default:            g = GL_UNKNOWN;
            endcase
        end
        return g;
    endfunction

    function automatic logic [7:0] font_col(input glyph_t idx, input logic [2:0] col);
        logic [39:0] cols;
        logic [7:0]  res;
        cols = (idx < GL_COUNT) ? FONT_ROM[idx] : '0;
        unique case (col)
            3'd0:    res = cols[39:32];
            3'd1:    res = cols[31:24];
            3'd2:    res = cols[23:16];
            3'd3:    res = cols[15:8];
            3'd4:    res = cols[7:0];
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/pfde_ram.sv */
// ----------------------------------------------------------------------------
// pfde_ram
// framebuffer byte store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module pfde_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [7:0]        rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]        wr_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/pfde_merge.sv */
// ----------------------------------------------------------------------------
// pfde_merge
// per-byte mask and pixel data for the active shape, merged into the old byte
// ----------------------------------------------------------------------------
`default_nettype none

module pfde_merge #(
    parameter int COL_W         = 7,
    parameter int PAGE_W        = 3,
    parameter int SCREEN_HEIGHT = 64
) (
    input  wire pfde_pkg::shape_t    shape,
    input  wire logic [COL_W-1:0]    col,
    input  wire logic [PAGE_W-1:0]   page,
    input  wire logic [7:0]          old_byte,
    output logic      [7:0]          new_byte
);

    localparam pfde_pkg::coord_t Y_MAX = pfde_pkg::coord_t'(SCREEN_HEIGHT - 1);

    pfde_pkg::coord_t cx;
    pfde_pkg::coord_t koff;
    logic             col_in;
    logic             col_edge;
    logic             gcol_in;
    logic             ocol_in;
    logic [7:0]       fbyte;
    logic [7:0]       mask;
    logic [7:0]       data;

    assign cx       = pfde_pkg::coord_t'({{(pfde_pkg::COORD_W-COL_W){1'b0}}, col});
    assign koff     = cx - shape.xa;
    assign col_in   = (cx >= shape.xa) && (cx <= shape.xb);
    assign col_edge = (cx == shape.xa) || (cx == shape.xb);
    assign gcol_in  = (koff >= 0) && (koff <= 4);
    assign ocol_in  = (koff >= 0) && (koff <= 5);
    assign fbyte    = pfde_pkg::font_col(shape.glyph, koff[2:0]);

    always_comb
    begin
        pfde_pkg::coord_t r;
        pfde_pkg::coord_t joff;
        logic             row_in;
        logic             row_edge;
        logic             g_in;
        logic             g_out;
        logic             lit;
        logic             m;
        logic             d;
        for (int b = 0; b < 8; b++)
        begin
            r        = pfde_pkg::coord_t'({{(pfde_pkg::COORD_W-PAGE_W-3){1'b0}}, page, 3'(b)});
            joff     = r - shape.ya;
            row_in   = (r >= shape.ya) && (r <= shape.yb);
            row_edge = (r == shape.ya) || (r == shape.yb);
            g_in     = gcol_in && (joff >= 0) && (joff <= 6);
            g_out    = shape.invert && ocol_in && (joff >= 0) && (joff <= 7);
            lit      = fbyte[joff[2:0]];
            unique case (shape.mode)
                pfde_pkg::SH_BOX:
                begin
                    m = col_in && row_in;
                    d = shape.pen;
                end
                pfde_pkg::SH_FRAME:
                begin
                    m = (col_in && row_edge) || (row_in && col_edge);
                    d = shape.pen;
                end
                pfde_pkg::SH_GLYPH:
                begin
                    m = g_in || g_out;
                    d = g_in ? (lit ^ shape.invert) : 1'b1;
                end
                default:
                begin
                    m = 1'b0;
                    d = 1'b0;
                end
            endcase
            // rows past the bottom edge in a partial page are never written
            mask[b] = m && (r <= Y_MAX);
            data[b] = d;
        end
    end

    assign new_byte = (old_byte & ~mask) | (data & mask);

endmodule

`default_nettype wire

/* rtl/core/page_framebuffer_draw_engine.sv */
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine
// monochrome page-layout framebuffer with clear, pixel, box, outline, glyph and read
//
//   channel  dir  handshake          beat contents
//   cmd      in   cmd_valid/stall    func, pos_x, pos_y, rect_width,
//                                     rect_height, pen, char_code, invert
//   rd       out  rd_valid/stall     pixel_byte
//
// a drawing command visits each byte of its clipped bounding box
// (glyph: up to 12 bytes, clear: SCREEN_WIDTH*pages), paced by the single
// read-modify-write pass through the byte store
// after reset a clearing pass over SCREEN_WIDTH*pages bytes holds cmd_stall
// a read beat is held in the output register while rd_stall is high
// ----------------------------------------------------------------------------
`default_nettype none

module page_framebuffer_draw_engine #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_stall,
    input  wire logic [2:0]        func,
    input  wire logic signed [8:0] pos_x,
    input  wire logic signed [8:0] pos_y,
    input  wire logic [7:0]        rect_width,
    input  wire logic [7:0]        rect_height,
    input  wire logic              pen,
    input  wire logic [7:0]        char_code,
    input  wire logic              invert,
    output logic                   rd_valid,
    input  wire logic              rd_stall,
    output logic [7:0]             pixel_byte
);

`include "page_framebuffer_draw_engine_defines.svh"

    localparam int PAGES  = (SCREEN_HEIGHT + 7) / 8;
    localparam int DEPTH  = SCREEN_WIDTH * PAGES;
    localparam int COL_W  = $clog2(SCREEN_WIDTH);
    localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int ROW_W  = PAGE_W + 3;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam pfde_pkg::coord_t X_MAX = pfde_pkg::coord_t'(SCREEN_WIDTH - 1);
    localparam pfde_pkg::coord_t Y_MAX = pfde_pkg::coord_t'(SCREEN_HEIGHT - 1);
    localparam logic [ADDR_W-1:0] PAGE_STEP = ADDR_W'(SCREEN_WIDTH);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SHAPE  = 3'd2;
    localparam logic [2:0] ST_BOUNDS = 3'd3;
    localparam logic [2:0] ST_WALK   = 3'd4;
    localparam logic [2:0] ST_RDWAIT = 3'd5;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;

    logic [2:0]          func_reg;
    logic signed [8:0]   x_reg;
    logic signed [8:0]   y_reg;
    logic [7:0]          w_reg;
    logic [7:0]          h_reg;
    logic                pen_reg;
    logic [7:0]          code_reg;
    logic                inv_reg;

    pfde_pkg::shape_t    shape_reg;
    pfde_pkg::shape_t    shape_next;

    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_lo_reg;
    logic [COL_W-1:0]    col_hi_reg;
    logic [PAGE_W-1:0]   page_reg;
    logic [PAGE_W-1:0]   page_hi_reg;
    logic [ADDR_W-1:0]   base_reg;

    logic                wr_pending_reg;
    logic [ADDR_W-1:0]   wr_addr_reg;
    logic [COL_W-1:0]    wr_col_reg;
    logic [PAGE_W-1:0]   wr_page_reg;

    logic                rd_valid_reg;
    logic [7:0]          pixel_byte_reg;

    logic                cmd_accept;
    pfde_pkg::coord_t    xs;
    pfde_pkg::coord_t    ys;
    pfde_pkg::coord_t    wx;
    pfde_pkg::coord_t    hy;
    logic                rd_on;
    logic [ADDR_W-1:0]   rd_point_addr;
    logic                is_read;

    pfde_pkg::coord_t    cl;
    pfde_pkg::coord_t    ch;
    pfde_pkg::coord_t    rl;
    pfde_pkg::coord_t    rh;
    pfde_pkg::coord_t    clc;
    pfde_pkg::coord_t    chc;
    pfde_pkg::coord_t    rlc;
    pfde_pkg::coord_t    rhc;
    logic                box_live;
    logic [PAGE_W-1:0]   page_lo;

    logic [ADDR_W-1:0]   walk_addr;
    logic                col_last;
    logic                page_last;

    logic                mem_rd_en;
    logic [ADDR_W-1:0]   mem_rd_addr;
    logic [7:0]          mem_rd_data;
    logic [7:0]          mem_wr_data;

    assign cmd_stall  = (state_reg != ST_IDLE) ||
                        ((func == pfde_pkg::FN_READ) && rd_valid_reg && rd_stall);
    assign cmd_accept = cmd_valid && !cmd_stall;

    // command decode
    assign xs      = pfde_pkg::coord_t'(x_reg);
    assign ys      = pfde_pkg::coord_t'(y_reg);
    assign wx      = xs + pfde_pkg::coord_t'({3'b000, w_reg}) - pfde_pkg::coord_t'(1);
    assign hy      = ys + pfde_pkg::coord_t'({3'b000, h_reg}) - pfde_pkg::coord_t'(1);
    assign is_read = (func_reg == pfde_pkg::FN_READ);
    assign rd_on   = (xs >= 0) && (xs <= X_MAX) && (ys >= 0) && (ys <= Y_MAX);
    assign rd_point_addr = ADDR_W'(ys[ROW_W-1:3]) * PAGE_STEP + ADDR_W'(xs[COL_W-1:0]);

    always_comb
    begin
        shape_next        = '0;
        shape_next.mode   = pfde_pkg::SH_BOX;
        shape_next.xa     = '0;
        shape_next.xb     = X_MAX;
        shape_next.ya     = '0;
        shape_next.yb     = Y_MAX;
        shape_next.pen    = 1'b0;
        shape_next.invert = 1'b0;
        shape_next.glyph  = pfde_pkg::GL_BLANK;
        if (state_reg == ST_SHAPE)
        begin
            unique case (func_reg)
                pfde_pkg::FN_PIXEL:
                begin
                    shape_next.xa  = xs;
                    shape_next.xb  = xs;
                    shape_next.ya  = ys;
                    shape_next.yb  = ys;
                    shape_next.pen = pen_reg;
                end
                pfde_pkg::FN_FILL, pfde_pkg::FN_OUTLINE:
                begin
                    shape_next.mode = (func_reg == pfde_pkg::FN_OUTLINE) ?
                                      pfde_pkg::SH_FRAME : pfde_pkg::SH_BOX;
                    shape_next.xa   = xs;
                    shape_next.xb   = wx;
                    shape_next.ya   = ys;
                    shape_next.yb   = hy;
                    shape_next.pen  = pen_reg;
                end
                pfde_pkg::FN_CHAR:
                begin
                    shape_next.mode   = pfde_pkg::SH_GLYPH;
                    shape_next.xa     = xs;
                    shape_next.xb     = xs + pfde_pkg::coord_t'(5);
                    shape_next.ya     = ys;
                    shape_next.yb     = ys + pfde_pkg::coord_t'(7);
                    shape_next.invert = inv_reg;
                    shape_next.glyph  = pfde_pkg::pick_glyph(code_reg);
                end
                default:
                begin
                    shape_next.pen = 1'b0;
                end
            endcase
        end
    end

    // bounding box of the shape, clipped to the screen
    always_comb
    begin
        if (shape_reg.mode == pfde_pkg::SH_FRAME)
        begin
            cl = (shape_reg.xa < shape_reg.xb) ? shape_reg.xa : shape_reg.xb;
            ch = (shape_reg.xa < shape_reg.xb) ? shape_reg.xb : shape_reg.xa;
            rl = (shape_reg.ya < shape_reg.yb) ? shape_reg.ya : shape_reg.yb;
            rh = (shape_reg.ya < shape_reg.yb) ? shape_reg.yb : shape_reg.ya;
        end
        else
        begin
            cl = shape_reg.xa;
            ch = shape_reg.xb;
            rl = shape_reg.ya;
            rh = shape_reg.yb;
        end
        clc = (cl < 0) ? pfde_pkg::coord_t'(0) : cl;
        chc = (ch > X_MAX) ? X_MAX : ch;
        rlc = (rl < 0) ? pfde_pkg::coord_t'(0) : rl;
        rhc = (rh > Y_MAX) ? Y_MAX : rh;
        box_live = (cl <= ch) && (rl <= rh) && (cl <= X_MAX) && (ch >= 0) &&
                   (rl <= Y_MAX) && (rh >= 0);
    end

    assign page_lo   = rlc[ROW_W-1:3];
    assign walk_addr = base_reg + ADDR_W'(col_reg);
    assign col_last  = (col_reg == col_hi_reg);
    assign page_last = (page_reg == page_hi_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                state_next = ST_BOUNDS;
            end
            ST_IDLE:
            begin
                if (cmd_accept)
                begin
                    state_next = ST_SHAPE;
                end
            end
            ST_SHAPE:
            begin
                priority if (is_read)
                begin
                    state_next = rd_on ? ST_RDWAIT : ST_IDLE;
                end
                else if (func_reg <= pfde_pkg::FN_CHAR)
                begin
                    state_next = ST_BOUNDS;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_BOUNDS:
            begin
                state_next = box_live ? ST_WALK : ST_IDLE;
            end
            ST_WALK:
            begin
                if (col_last && page_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RDWAIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign mem_rd_en   = (state_reg == ST_WALK) ||
                         ((state_reg == ST_SHAPE) && is_read && rd_on);
    assign mem_rd_addr = (state_reg == ST_WALK) ? walk_addr : rd_point_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            wr_pending_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wr_pending_reg <= (state_reg == ST_WALK);
            if ((state_reg == ST_RDWAIT) ||
                ((state_reg == ST_SHAPE) && is_read && !rd_on))
            begin
                rd_valid_reg <= 1'b1;
            end
            else if (!rd_stall)
            begin
                rd_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_accept)
        begin
            func_reg <= func;
            x_reg    <= pos_x;
            y_reg    <= pos_y;
            w_reg    <= rect_width;
            h_reg    <= rect_height;
            pen_reg  <= pen;
            code_reg <= char_code;
            inv_reg  <= invert;
        end
        if ((state_reg == ST_INIT) || (state_reg == ST_SHAPE))
        begin
            shape_reg <= shape_next;
        end
        if (state_reg == ST_BOUNDS)
        begin
            col_reg     <= clc[COL_W-1:0];
            col_lo_reg  <= clc[COL_W-1:0];
            col_hi_reg  <= chc[COL_W-1:0];
            page_reg    <= page_lo;
            page_hi_reg <= rhc[ROW_W-1:3];
            base_reg    <= ADDR_W'(page_lo) * PAGE_STEP;
        end
        else if (state_reg == ST_WALK)
        begin
            if (col_last)
            begin
                col_reg  <= col_lo_reg;
                page_reg <= page_reg + PAGE_W'(1);
                base_reg <= base_reg + PAGE_STEP;
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
        wr_addr_reg <= walk_addr;
        wr_col_reg  <= col_reg;
        wr_page_reg <= page_reg;
        if (state_reg == ST_RDWAIT)
        begin
            pixel_byte_reg <= mem_rd_data;
        end
        else if ((state_reg == ST_SHAPE) && is_read && !rd_on)
        begin
            pixel_byte_reg <= '0;
        end
    end

    pfde_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (wr_pending_reg),
        .wr_addr (wr_addr_reg),
        .wr_data (mem_wr_data)
    );

    pfde_merge #(
        .COL_W         (COL_W),
        .PAGE_W        (PAGE_W),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_merge (
        .shape    (shape_reg),
        .col      (wr_col_reg),
        .page     (wr_page_reg),
        .old_byte (mem_rd_data),
        .new_byte (mem_wr_data)
    );

    assign rd_valid   = rd_valid_reg;
    assign pixel_byte = pixel_byte_reg;

    `PFDE_CHECK_NEXT(a_walk_writes_back, state_reg == ST_WALK, wr_pending_reg, "no write-back")
    `PFDE_CHECK(a_write_from_walk, wr_pending_reg, $past(state_reg) == ST_WALK, "stray write")
    `PFDE_CHECK(a_rd_slot_free, state_reg == ST_RDWAIT, !rd_valid_reg, "result overwritten")
    `PFDE_CHECK(a_no_same_byte, wr_pending_reg && mem_rd_en, mem_rd_addr != wr_addr_reg, "overlap")

endmodule

`default_nettype wire
